// ===== rtl/core/concat_volume_request_splitter_assert.svh =====
// Assertion macros for the concatenated-volume request splitter.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef CONCAT_VOLUME_REQUEST_SPLITTER_ASSERT_SVH
`define CONCAT_VOLUME_REQUEST_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: ante |-> cons.
`define CVRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cvrs check failed");

// Next-cycle implication: ante |=> cons.
`define CVRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cvrs check failed");

`else

`define CVRS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CVRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/cvrs_pkg.sv =====
// Shared types and constants of the concatenated-volume request splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cvrs_pkg;

    localparam int NUM_DEVICES = 4;
    localparam int NUM_REGS    = 4;
    // Devices that can ever be touched: those that have a size register.
    localparam int NUM_WALK    = (NUM_DEVICES < NUM_REGS) ? NUM_DEVICES : NUM_REGS;
    localparam int WALK_W      = (NUM_WALK > 1) ? $clog2(NUM_WALK) : 1;

    localparam int ADDR_W      = $clog2(NUM_REGS) + 2;
    localparam int REG_IDX_W   = ADDR_W - 2;
    localparam int DATA_W      = 32;

    localparam int OP_W        = 2;
    localparam int DEV_W       = 2;
    localparam int BLK_W       = 32;
    localparam int BUF_W       = 33;
    localparam int TOTAL_W     = 34;

    localparam logic [OP_W-1:0] OP_TRIM = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_ARGS  = 2'd2,
        STAT_NONE  = 2'd3
    } cvrs_status_t;

    typedef logic [NUM_WALK-1:0][BLK_W-1:0] cvrs_sizes_t;

    // Controller to datapath.
    typedef struct packed {
        logic         load;
        logic         emit;
        logic         advance;
        cvrs_status_t sel;
    } cvrs_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic range_err;
        logic hit;
        logic args_err;
        logic piece_last;
        logic dev_last;
        logic out_free;
    } cvrs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cvrs_regs.sv =====
// APB register file with the device sizes and a running total of them.
// Depends on cvrs_pkg.
`default_nettype none

module cvrs_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cvrs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cvrs_pkg::DATA_W-1:0]   pwdata,
    output logic      [cvrs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output cvrs_pkg::cvrs_sizes_t              dev_size,
    output logic      [cvrs_pkg::TOTAL_W-1:0]  total
);
    import cvrs_pkg::*;

    cvrs_sizes_t          size_reg;
    cvrs_sizes_t          size_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [BLK_W-1:0]     old_size;
    logic                 idx_hit;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        size_next = size_reg;
        old_size  = '0;
        idx_hit   = 1'b0;
        prdata    = '0;
        for (int i = 0; i < NUM_WALK; i++) begin
            if (reg_idx == REG_IDX_W'(i)) begin
                old_size = size_reg[i];
                idx_hit  = 1'b1;
                prdata   = size_reg[i];
                if (wr_en) begin
                    size_next[i] = pwdata;
                end
            end
        end
        // Swap the old size for the new one in the total.
        total_next = total_reg;
        if (wr_en && idx_hit) begin
            total_next = total_reg + {2'b00, pwdata} - {2'b00, old_size};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= '0;
            total_reg <= '0;
        end else begin
            size_reg  <= size_next;
            total_reg <= total_next;
        end
    end

    assign dev_size = size_reg;
    assign total    = total_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cvrs_dp.sv =====
// Datapath: request registers, device walk arithmetic and result register.
// Depends on cvrs_pkg; driven by cvrs_ctrl.
`default_nettype none

module cvrs_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  cvrs_pkg::cvrs_cmd_t               cmd,
    output cvrs_pkg::cvrs_sts_t               sts,
    input  cvrs_pkg::cvrs_sizes_t             dev_size,
    input  wire logic [cvrs_pkg::TOTAL_W-1:0] total,
    input  wire logic [cvrs_pkg::OP_W-1:0]    s_op,
    input  wire logic                         s_handle_valid,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_buf_offset,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_vol_offset,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_blocks,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [1:0]                   m_status,
    output logic      [cvrs_pkg::DEV_W-1:0]   m_device,
    output logic      [cvrs_pkg::OP_W-1:0]    m_kind,
    output logic      [cvrs_pkg::BUF_W-1:0]   m_sub_buf_offset,
    output logic      [cvrs_pkg::BLK_W-1:0]   m_local_offset,
    output logic      [cvrs_pkg::BLK_W-1:0]   m_sub_blocks,
    output logic                              m_last
);
    import cvrs_pkg::*;

    logic [OP_W-1:0]   op_reg;
    logic              handle_reg;
    logic [BUF_W-1:0]  buf_ptr_reg;
    logic [BLK_W-1:0]  offset_reg;
    logic [BLK_W-1:0]  residual_reg;
    logic [WALK_W-1:0] idx_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DEV_W-1:0]  out_device_reg;
    logic [OP_W-1:0]   out_kind_reg;
    logic [BUF_W-1:0]  out_buf_reg;
    logic [BLK_W-1:0]  out_doff_reg;
    logic [BLK_W-1:0]  out_blocks_reg;
    logic              out_last_reg;

    logic [BLK_W-1:0]  size;
    logic [BLK_W-1:0]  room;
    logic [BLK_W-1:0]  piece;
    logic [BUF_W-1:0]  req_end;
    logic              is_ok;

    always_comb begin
        size = '0;
        for (int i = 0; i < NUM_WALK; i++) begin
            if (idx_reg == WALK_W'(i)) begin
                size = dev_size[i];
            end
        end
    end

    // Offset and residual still hold the request values during the check.
    assign req_end = {1'b0, offset_reg} + {1'b0, residual_reg};
    assign room    = size - offset_reg;

    always_comb begin
        sts.range_err  = {1'b0, req_end} > total;
        sts.hit        = offset_reg < size;
        sts.args_err   = !handle_reg && (op_reg != OP_TRIM);
        sts.piece_last = residual_reg <= room;
        sts.dev_last   = idx_reg == WALK_W'(NUM_WALK - 1);
        sts.out_free   = !out_valid_reg || m_ready;
    end

    assign piece = sts.piece_last ? residual_reg : room;
    assign is_ok = cmd.sel == STAT_OK;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_op;
            handle_reg   <= s_handle_valid;
            buf_ptr_reg  <= {1'b0, s_buf_offset};
            offset_reg   <= s_vol_offset;
            residual_reg <= s_blocks;
            idx_reg      <= '0;
        end else if (cmd.advance) begin
            idx_reg <= idx_reg + 1'b1;
            if (sts.hit) begin
                buf_ptr_reg  <= buf_ptr_reg + {1'b0, piece};
                residual_reg <= residual_reg - piece;
                offset_reg   <= '0;
            end else begin
                offset_reg <= offset_reg - size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Error and empty results carry only status and kind, with last set.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.sel;
            out_kind_reg   <= op_reg;
            out_device_reg <= is_ok ? DEV_W'(idx_reg) : '0;
            out_buf_reg    <= is_ok ? buf_ptr_reg : '0;
            out_doff_reg   <= is_ok ? offset_reg : '0;
            out_blocks_reg <= is_ok ? piece : '0;
            out_last_reg   <= is_ok ? sts.piece_last : 1'b1;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_device         = out_device_reg;
    assign m_kind           = out_kind_reg;
    assign m_sub_buf_offset = out_buf_reg;
    assign m_local_offset   = out_doff_reg;
    assign m_sub_blocks     = out_blocks_reg;
    assign m_last           = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cvrs_ctrl.sv =====
// Controller state machine: accept, range check, then walk the devices.
// Depends on cvrs_pkg and the assertion macro header.
`default_nettype none

`include "concat_volume_request_splitter_assert.svh"

module cvrs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  cvrs_pkg::cvrs_sts_t sts,
    output cvrs_pkg::cvrs_cmd_t cmd
);
    import cvrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_WALK  = 3'b100
    } cvrs_state_t;

    cvrs_state_t state_reg;
    cvrs_state_t state_next;

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.sel     = STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!sts.range_err) begin
                    state_next = ST_WALK;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = STAT_RANGE;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (sts.hit) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        if (sts.args_err) begin
                            cmd.sel    = STAT_ARGS;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.advance = 1'b1;
                            if (sts.piece_last) begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end else if (!sts.dev_last) begin
                    cmd.advance = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = STAT_NONE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CVRS_ASSERT_NEXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready, state_reg == ST_CHECK)
    `CVRS_ASSERT_IMP(a_emit_needs_room, aclk, aresetn, cmd.emit, sts.out_free)
    `CVRS_ASSERT_IMP(a_advance_in_walk, aclk, aresetn, cmd.advance, state_reg == ST_WALK && !(sts.hit && sts.args_err))
    `CVRS_ASSERT_NEXT(a_none_ends_walk, aclk, aresetn, cmd.emit && cmd.sel == STAT_NONE, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/core/concat_volume_request_splitter.sv =====
// Top level of the concatenated-volume request splitter.
// Depends on cvrs_pkg, cvrs_regs, cvrs_dp and cvrs_ctrl.
//
//   channel | direction | handshake            | word
//   s_      | in        | s_valid / s_ready    | op, handle flag, buffer/volume offset, length
//   m_      | out       | m_valid / m_ready    | status, device, kind, offsets, length, last
//   apb     | in        | psel/penable/pready  | device block counts, 32 bits each
//
// A request is accepted, then range-checked against the running total of the device
// sizes, then walked device by device (up to four devices), the walk stopping at the
// device that holds the final piece.
// Each walk step does one subtract and compare on the current device size.
// A full result register sits on m_; the walk holds while it cannot be refilled.
// Reset (aresetn, synchronous, active low) clears the size registers to zero.
`default_nettype none

module concat_volume_request_splitter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // request words
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cvrs_pkg::OP_W-1:0]    s_op,
    input  wire logic                         s_handle_valid,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_buf_offset,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_vol_offset,
    input  wire logic [cvrs_pkg::BLK_W-1:0]   s_blocks,
    // sub-request words
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [1:0]                   m_status,
    output logic      [cvrs_pkg::DEV_W-1:0]   m_device,
    output logic      [cvrs_pkg::OP_W-1:0]    m_kind,
    output logic      [cvrs_pkg::BUF_W-1:0]   m_sub_buf_offset,
    output logic      [cvrs_pkg::BLK_W-1:0]   m_local_offset,
    output logic      [cvrs_pkg::BLK_W-1:0]   m_sub_blocks,
    output logic                              m_last,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cvrs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cvrs_pkg::DATA_W-1:0]  pwdata,
    output logic      [cvrs_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import cvrs_pkg::*;

    cvrs_sizes_t        dev_size;
    logic [TOTAL_W-1:0] total;
    cvrs_cmd_t          cmd;
    cvrs_sts_t          sts;

    // Size registers; the total follows every write in the same cycle.
    cvrs_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .dev_size (dev_size),
        .total    (total)
    );

    // Sequence: accept, check range, then walk devices in order.
    cvrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the request, split it at device boundaries, register each word out.
    cvrs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .dev_size         (dev_size),
        .total            (total),
        .s_op             (s_op),
        .s_handle_valid   (s_handle_valid),
        .s_buf_offset     (s_buf_offset),
        .s_vol_offset     (s_vol_offset),
        .s_blocks         (s_blocks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_device         (m_device),
        .m_kind           (m_kind),
        .m_sub_buf_offset (m_sub_buf_offset),
        .m_local_offset   (m_local_offset),
        .m_sub_blocks     (m_sub_blocks),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire
